// File: hdl/lsvm_pkg.sv
// lsvm_pkg: shared types, field widths and constants of the sample voice mixer
// depends on nothing; imported by the mixer top level
package lsvm_pkg;

   // default build parameters
   localparam int DEF_MAX_VOICES       = 32;
   localparam int DEF_SAMPLE_MEM_BYTES = 131072;
   localparam int DEF_FRACTION_BITS    = 16;

   // fixed field widths of the channels
   localparam int CMD_W       = 2;
   localparam int FIELD_ADDR_W = 17;
   localparam int SAMPLE_W    = 8;
   localparam int CHANNEL_W   = 5;
   localparam int STEP_W      = 24;
   localparam int GAIN_W      = 8;
   localparam int AUDIO_W     = 16;
   localparam int CCOUNT_W    = 6;
   localparam int VCOUNT_W    = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;

   // reset values of the control registers
   localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 6'd4;

   // output saturation limits
   localparam int SAT_HI = 32'sh0000_7fff;
   localparam int SAT_LO = -32'sh0000_8000;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_SAMPLE = 2'd0,
      CMD_SET_VOICE    = 2'd1,
      CMD_RENDER       = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT  = 1'b0,
      CSR_PLAYING_ENABLE = 1'b1
   } csr_index_type;

   // one voice's static registers as held in the voice ram
   typedef struct packed {
      logic                    enable;
      logic [FIELD_ADDR_W-1:0] base;
      logic [FIELD_ADDR_W-1:0] len;
      logic [FIELD_ADDR_W-1:0] loop_begin;
      logic [FIELD_ADDR_W-1:0] loop_len;
      logic [STEP_W-1:0]       step;
      logic [GAIN_W-1:0]       gain;
   } voice_regs_type;

   // compare-subtract steps that bring base plus integer position below the memory size
   function automatic int mod_steps(input longint mem_bytes);
      longint limit;
      int     n;
      int     k;
      limit = 2 * ((longint'(1) << FIELD_ADDR_W) - 1);
      n = 0;
      for (k = 0; k < 32; k++) begin
         if ((mem_bytes << k) <= limit) begin
            n = k + 1;
         end
      end
      return n;
   endfunction

endpackage

// File: hdl/lsvm_ram.sv
// lsvm_ram: generic single write port, single read port ram with registered read
// no dependencies
module lsvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lsvm_alu.sv
// lsvm_alu: shared add/subtract unit with carry out, used for the adding and comparing mixer steps
// no dependencies
module lsvm_alu #(
   parameter int WIDTH = 34
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             sub,
   output logic [WIDTH-1:0] result,
   output logic             carry
);

   logic [WIDTH-1:0] b_op;

   // on subtract, carry high means a >= b
   assign b_op = sub ? ~b : b;
   assign {carry, result} = {1'b0, a} + {1'b0, b_op} + (WIDTH + 1)'(sub);

endmodule

// File: hdl/looping_sample_voice_mixer_core.sv
// looping_sample_voice_mixer_core: multi-voice looping wavetable mixer top level
// depends on lsvm_pkg, lsvm_ram and lsvm_alu
//
// Usage: the req_ channel carries commands. Write-sample and set-voice commands
// take effect in the cycle of their transfer and produce no result. A render
// command produces one rsp_ transfer with the saturated mixed frame.
// The block takes one command at a time: req_stall is high from a render
// transfer until its result has been loaded into the output register.
// Render sequence: with playing off or no voice counted it goes straight to done;
// else per voice the registers are read and the loop end formed; a disabled voice
// ends there, an enabled one with a loop is wrapped at or past its loop end and checked
// against its length; one outside its sample goes to the position write-back, the
// others pass address, MOD_STEPS reduction steps, fetch, multiply, accumulate, step
// and write-back. One shared adder serves every voice, one step per cycle; MOD_STEPS
// is 1 for the default memory size. Write and set-voice commands never raise req_stall.
// The result waits in an output register; the next command is taken while it
// waits, and a render finishing behind a stalled result holds in its final
// state until the register frees up.
// Reset clears all voices (valid bits per voice, no clearing pass), sets
// channel_count to 4 and playing off. Sample memory is undefined until written.
module looping_sample_voice_mixer_core
   import lsvm_pkg::*;
#(
   parameter int MAX_VOICES       = DEF_MAX_VOICES,
   parameter int SAMPLE_MEM_BYTES = DEF_SAMPLE_MEM_BYTES,
   parameter int FRACTION_BITS    = DEF_FRACTION_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   // command channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [FIELD_ADDR_W-1:0]    req_address,
   input  logic signed [SAMPLE_W-1:0] req_sample_byte,
   input  logic [CHANNEL_W-1:0]       req_channel,
   input  logic                       req_voice_enable,
   input  logic [FIELD_ADDR_W-1:0]    req_voice_start,
   input  logic [FIELD_ADDR_W-1:0]    req_voice_length,
   input  logic [FIELD_ADDR_W-1:0]    req_loop_start,
   input  logic [FIELD_ADDR_W-1:0]    req_loop_length,
   input  logic [STEP_W-1:0]          req_step,
   input  logic [GAIN_W-1:0]          req_volume,
   input  logic                       req_restart_position,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [AUDIO_W-1:0]  rsp_audio_sample,
   // configuration port
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int VW         = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int AW         = (SAMPLE_MEM_BYTES > 1) ? $clog2(SAMPLE_MEM_BYTES) : 1;
   localparam int POS_W      = FIELD_ADDR_W + FRACTION_BITS;
   localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
   localparam int SUM_W      = PROD_W + $clog2(MAX_VOICES);
   localparam int ALU_W      = (POS_W + 1 > SUM_W) ? POS_W + 1 : SUM_W;
   localparam int ASUM_W     = FIELD_ADDR_W + 1;
   localparam int MOD_STEPS  = mod_steps(longint'(SAMPLE_MEM_BYTES));
   localparam int MODK_W     = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
   localparam int VREGS_W    = $bits(voice_regs_type);
   localparam logic [POS_W-1:0]        POS_MAX = '1;
   localparam logic signed [SUM_W-1:0] SUM_HI  = SUM_W'(SAT_HI);
   localparam logic signed [SUM_W-1:0] SUM_LO  = SUM_W'(SAT_LO);

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_READ     = 14'b00000000000010,
      ST_LOOP_END = 14'b00000000000100,
      ST_LOOP_CMP = 14'b00000000001000,
      ST_LOOP_SUB = 14'b00000000010000,
      ST_LEN_CMP  = 14'b00000000100000,
      ST_ADDR     = 14'b00000001000000,
      ST_MOD      = 14'b00000010000000,
      ST_FETCH    = 14'b00000100000000,
      ST_MUL      = 14'b00001000000000,
      ST_ACC      = 14'b00010000000000,
      ST_STEP     = 14'b00100000000000,
      ST_WRITE    = 14'b01000000000000,
      ST_DONE     = 14'b10000000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [VCOUNT_W-1:0]        cnt_ff, cnt_in;
   logic [MODK_W-1:0]          modk_ff, modk_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [ASUM_W-1:0]          tmp_ff, tmp_in;
   logic [ASUM_W-1:0]          addr_ff, addr_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [AUDIO_W-1:0]  rsp_audio_ff, rsp_audio_in;
   logic [CCOUNT_W-1:0]        ccount_ff, ccount_in;
   logic                       playing_ff, playing_in;
   logic [MAX_VOICES-1:0]      param_valid_ff, param_valid_in;
   logic [MAX_VOICES-1:0]      pos_valid_ff, pos_valid_in;

   logic                       req_acc;
   logic                       out_free;
   logic                       chan_ok;
   logic                       last_voice;
   logic [VCOUNT_W-1:0]        count_eff;
   logic [VW-1:0]              vidx;
   logic [VW-1:0]              chan_idx;

   logic                       smem_wr_en;
   logic [SAMPLE_W-1:0]        smem_rdata;
   logic                       vreg_wr_en;
   voice_regs_type             vreg_wdata;
   logic [VREGS_W-1:0]         vreg_rdata;
   voice_regs_type             vr;
   logic                       pmem_wr_en;
   logic [VW-1:0]              pmem_wr_addr;
   logic [POS_W-1:0]           pmem_wdata;
   logic [POS_W-1:0]           pmem_rdata;
   logic [POS_W-1:0]           pos_rd;
   logic                       voice_on;

   logic [ALU_W-1:0]           alu_a;
   logic [ALU_W-1:0]           alu_b;
   logic                       alu_sub;
   logic [ALU_W-1:0]           alu_res;
   logic                       alu_carry;

   // handshake and voice bookkeeping
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_eff = ({1'b0, ccount_ff} > VCOUNT_W'(MAX_VOICES)) ?
                      VCOUNT_W'(MAX_VOICES) : {1'b0, ccount_ff};
   assign vidx      = cnt_ff[VW-1:0];
   assign chan_idx  = VW'(req_channel);
   assign chan_ok   = (VCOUNT_W'(req_channel) < VCOUNT_W'(MAX_VOICES));
   assign last_voice = ((cnt_ff + 1'b1) == count_eff);

   // sample memory, written on a sample transfer inside the memory
   assign smem_wr_en = req_acc && (cmd_type'(req_command) == CMD_WRITE_SAMPLE) &&
                       (32'(req_address) < 32'(SAMPLE_MEM_BYTES));

   lsvm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (SAMPLE_MEM_BYTES)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (smem_wr_en),
      .wr_addr (AW'(req_address)),
      .wr_data (req_sample_byte),
      .rd_addr (AW'(addr_ff)),
      .rd_data (smem_rdata)
   );

   // voice register ram
   assign vreg_wr_en = req_acc && (cmd_type'(req_command) == CMD_SET_VOICE) && chan_ok;

   always_comb begin
      vreg_wdata.enable     = req_voice_enable;
      vreg_wdata.base       = req_voice_start;
      vreg_wdata.len        = req_voice_length;
      vreg_wdata.loop_begin = req_loop_start;
      vreg_wdata.loop_len   = req_loop_length;
      vreg_wdata.step       = req_step;
      vreg_wdata.gain       = req_volume;
   end

   lsvm_ram #(
      .WIDTH (VREGS_W),
      .DEPTH (MAX_VOICES)
   ) u_voice_ram (
      .clock   (clock),
      .wr_en   (vreg_wr_en),
      .wr_addr (chan_idx),
      .wr_data (vreg_wdata),
      .rd_addr (vidx),
      .rd_data (vreg_rdata)
   );

   assign vr       = voice_regs_type'(vreg_rdata);
   assign voice_on = vr.enable && param_valid_ff[vidx];

   // position ram: written back by the render, cleared by a restart
   always_comb begin
      if (state_ff == ST_WRITE) begin
         pmem_wr_en   = 1'b1;
         pmem_wr_addr = vidx;
         pmem_wdata   = pos_ff;
      end else begin
         pmem_wr_en   = vreg_wr_en && req_restart_position;
         pmem_wr_addr = chan_idx;
         pmem_wdata   = '0;
      end
   end

   lsvm_ram #(
      .WIDTH (POS_W),
      .DEPTH (MAX_VOICES)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (pmem_wr_en),
      .wr_addr (pmem_wr_addr),
      .wr_data (pmem_wdata),
      .rd_addr (vidx),
      .rd_data (pmem_rdata)
   );

   assign pos_rd = pos_valid_ff[vidx] ? pmem_rdata : '0;

   // valid bits per voice
   always_comb begin
      param_valid_in = param_valid_ff;
      pos_valid_in   = pos_valid_ff;
      if (vreg_wr_en) begin
         param_valid_in[chan_idx] = 1'b1;
      end
      if (pmem_wr_en) begin
         pos_valid_in[pmem_wr_addr] = 1'b1;
      end
   end

   // shared adder
   lsvm_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .carry  (alu_carry)
   );

   // render sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      modk_in  = modk_ff;
      pos_in   = pos_ff;
      tmp_in   = tmp_ff;
      addr_in  = addr_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      alu_a    = '0;
      alu_b    = '0;
      alu_sub  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (cmd_type'(req_command) == CMD_RENDER)) begin
               sum_in = '0;
               cnt_in = '0;
               if (playing_ff && (count_eff != '0)) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOOP_END;
         end
         ST_LOOP_END: begin
            // loop end in whole bytes; latch the stored position
            alu_a  = ALU_W'(vr.loop_begin);
            alu_b  = ALU_W'(vr.loop_len);
            tmp_in = alu_res[ASUM_W-1:0];
            pos_in = pos_rd;
            if (voice_on) begin
               state_in = ST_LOOP_CMP;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = last_voice ? ST_DONE : ST_READ;
            end
         end
         ST_LOOP_CMP: begin
            alu_a   = ALU_W'(pos_ff);
            alu_b   = ALU_W'(tmp_ff) << FRACTION_BITS;
            alu_sub = 1'b1;
            if ((vr.loop_len != '0) && alu_carry) begin
               state_in = ST_LOOP_SUB;
            end else begin
               state_in = ST_LEN_CMP;
            end
         end
         ST_LOOP_SUB: begin
            alu_a    = ALU_W'(pos_ff);
            alu_b    = ALU_W'(vr.loop_len) << FRACTION_BITS;
            alu_sub  = 1'b1;
            pos_in   = alu_res[POS_W-1:0];
            state_in = ST_LEN_CMP;
         end
         ST_LEN_CMP: begin
            // no carry means position below sample length
            alu_a    = ALU_W'(pos_ff);
            alu_b    = ALU_W'(vr.len) << FRACTION_BITS;
            alu_sub  = 1'b1;
            state_in = alu_carry ? ST_WRITE : ST_ADDR;
         end
         ST_ADDR: begin
            alu_a   = ALU_W'(vr.base);
            alu_b   = ALU_W'(pos_ff >> FRACTION_BITS);
            addr_in = alu_res[ASUM_W-1:0];
            modk_in = MODK_W'(MOD_STEPS - 1);
            state_in = (MOD_STEPS > 0) ? ST_MOD : ST_FETCH;
         end
         ST_MOD: begin
            // restoring reduction modulo the memory size
            alu_a   = ALU_W'(addr_ff);
            alu_b   = ALU_W'(SAMPLE_MEM_BYTES) << modk_ff;
            alu_sub = 1'b1;
            if (alu_carry) begin
               addr_in = alu_res[ASUM_W-1:0];
            end
            if (modk_ff == '0) begin
               state_in = ST_FETCH;
            end else begin
               modk_in = modk_ff - 1'b1;
            end
         end
         ST_FETCH: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = $signed(smem_rdata) * $signed({1'b0, vr.gain});
            state_in = ST_ACC;
         end
         ST_ACC: begin
            alu_a    = ALU_W'(sum_ff);
            alu_b    = ALU_W'(prod_ff);
            sum_in   = alu_res[SUM_W-1:0];
            state_in = ST_STEP;
         end
         ST_STEP: begin
            // advance with saturation at the top of the position range
            alu_a    = ALU_W'(pos_ff);
            alu_b    = ALU_W'(vr.step);
            pos_in   = alu_res[POS_W] ? POS_MAX : alu_res[POS_W-1:0];
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cnt_in   = cnt_ff + 1'b1;
            state_in = last_voice ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register with saturation to the audio range
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_audio_in = rsp_audio_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         if (sum_ff > SUM_HI) begin
            rsp_audio_in = AUDIO_W'(SAT_HI);
         end else if (sum_ff < SUM_LO) begin
            rsp_audio_in = AUDIO_W'(SAT_LO);
         end else begin
            rsp_audio_in = sum_ff[AUDIO_W-1:0];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_audio_sample = rsp_audio_ff;

   // configuration writes
   always_comb begin
      ccount_in  = ccount_ff;
      playing_in = playing_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CHANNEL_COUNT:  ccount_in  = csr_wdata;
            CSR_PLAYING_ENABLE: playing_in = csr_wdata[0];
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         ccount_ff      <= CCOUNT_RESET;
         playing_ff     <= 1'b0;
         param_valid_ff <= '0;
         pos_valid_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         ccount_ff      <= ccount_in;
         playing_ff     <= playing_in;
         param_valid_ff <= param_valid_in;
         pos_valid_ff   <= pos_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      modk_ff      <= modk_in;
      pos_ff       <= pos_in;
      tmp_ff       <= tmp_in;
      addr_ff      <= addr_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      rsp_audio_ff <= rsp_audio_in;
   end

`ifndef SYNTHESIS
   // fetch address has been reduced into the sample memory
   a_fetch_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (32'(addr_ff) < 32'(SAMPLE_MEM_BYTES)))
      else $error("sample fetch address beyond memory");

   // reduction step counter stays inside the step count
   a_modk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |-> (32'(modk_ff) < MOD_STEPS))
      else $error("modulo step counter out of range");

   // a finished frame always lands in the output register
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished frame not presented");
`endif

endmodule

// File: tb/tb_looping_sample_voice_mixer_core.sv
// tb_looping_sample_voice_mixer_core: self-checking testbench of the sample voice mixer
// depends on lsvm_pkg and looping_sample_voice_mixer_core; a scoreboard class predicts
// each rendered frame and checks every rsp_ transfer against it
module tb_looping_sample_voice_mixer_core;
   timeunit 1ns;
   timeprecision 1ps;
   import lsvm_pkg::*;

   localparam int VOICES     = DEF_MAX_VOICES;
   localparam int MEM_BYTES  = DEF_SAMPLE_MEM_BYTES;
   localparam int FRAC       = DEF_FRACTION_BITS;
   localparam int ADDR_MAX   = (1 << FIELD_ADDR_W) - 1;
   localparam int STEP_MAX   = (1 << STEP_W) - 1;
   localparam int ONE_STEP   = 1 << FRAC;
   localparam longint unsigned POS_LIMIT = (longint'(1) << (FIELD_ADDR_W + FRAC)) - 1;

   // command code the block does not decode
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int ITEM_TARGET    = 1725;
   localparam int QUIET_FROM     = ITEM_TARGET - 150;
   localparam int HOLD_CYCLES    = 300;
   localparam int OVERFLOW_RUNS  = 520;
   localparam int PHASE_GAP      = 20;
   localparam int FRAME_CYCLES   = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int COUNT_PICKS [11] = '{0, 1, 2, 3, 4, 8, 16, 31, 32, 33, 63};

   typedef struct {
      logic [CMD_W-1:0]        command;
      logic [FIELD_ADDR_W-1:0] address;
      logic [SAMPLE_W-1:0]     sample_byte;
      logic [CHANNEL_W-1:0]    channel;
      logic                    voice_enable;
      logic [FIELD_ADDR_W-1:0] voice_start;
      logic [FIELD_ADDR_W-1:0] voice_length;
      logic [FIELD_ADDR_W-1:0] loop_start;
      logic [FIELD_ADDR_W-1:0] loop_length;
      logic [STEP_W-1:0]       step;
      logic [GAIN_W-1:0]       volume;
      logic                    restart_position;
   } mixer_command_t;

   // predicts mixed frames from the accepted commands and checks the results
   class frame_scoreboard;
      bit signed [SAMPLE_W-1:0]  sample_mem [MEM_BYTES];
      bit                        written [MEM_BYTES];
      bit                        v_enable [VOICES];
      bit [FIELD_ADDR_W-1:0]     v_base [VOICES];
      bit [FIELD_ADDR_W-1:0]     v_len [VOICES];
      bit [FIELD_ADDR_W-1:0]     v_loop_begin [VOICES];
      bit [FIELD_ADDR_W-1:0]     v_loop_len [VOICES];
      bit [STEP_W-1:0]           v_step [VOICES];
      bit [GAIN_W-1:0]           v_gain [VOICES];
      longint unsigned           v_pos [VOICES];
      bit [CCOUNT_W-1:0]         ccount;
      bit                        playing;
      logic signed [AUDIO_W-1:0] expected_audio [$];
      int unsigned               fetch_addr [$];
      int                        errors;

      function new();
         ccount  = CCOUNT_RESET;
         playing = 1'b0;
         errors  = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_CHANNEL_COUNT) ccount = data[CCOUNT_W-1:0];
         else playing = data[0];
      endfunction

      // one frame over the counted voices; positions move only when commit is set
      function int mix_voices(bit commit);
         int              acc;
         int              n;
         int              v;
         longint unsigned pos;
         longint unsigned loop_end;
         longint unsigned addr;
         acc = 0;
         fetch_addr.delete();
         n = (ccount > VOICES) ? VOICES : ccount;
         for (v = 0; v < n; v++) begin
            if (v_enable[v]) begin
               pos = v_pos[v];
               // wrap back once at or past the loop end
               if (v_loop_len[v] != 0) begin
                  loop_end = (longint'(v_loop_begin[v]) + longint'(v_loop_len[v])) << FRAC;
                  if (loop_end <= pos) pos -= longint'(v_loop_len[v]) << FRAC;
               end
               // still inside the sample: fetch, scale and advance
               if (pos < (longint'(v_len[v]) << FRAC)) begin
                  addr = (longint'(v_base[v]) + (pos >> FRAC)) % MEM_BYTES;
                  fetch_addr.push_back(int'(addr));
                  acc += int'(sample_mem[addr]) * int'(v_gain[v]);
                  pos += v_step[v];
                  if (pos > POS_LIMIT) pos = POS_LIMIT;
               end
               if (commit) v_pos[v] = pos;
            end
         end
         return acc;
      endfunction

      function void note_request(mixer_command_t c);
         int acc;
         case (c.command)
            CMD_WRITE_SAMPLE: begin
               sample_mem[c.address] = c.sample_byte;
               written[c.address]    = 1'b1;
            end
            CMD_SET_VOICE: begin
               v_enable[c.channel]     = c.voice_enable;
               v_base[c.channel]       = c.voice_start;
               v_len[c.channel]        = c.voice_length;
               v_loop_begin[c.channel] = c.loop_start;
               v_loop_len[c.channel]   = c.loop_length;
               v_step[c.channel]       = c.step;
               v_gain[c.channel]       = c.volume;
               if (c.restart_position) v_pos[c.channel] = 0;
            end
            CMD_RENDER: begin
               acc = 0;
               if (playing) begin
                  acc = mix_voices(1'b1);
                  if (acc > SAT_HI) acc = SAT_HI;
                  else if (acc < SAT_LO) acc = SAT_LO;
               end
               expected_audio.push_back(acc[AUDIO_W-1:0]);
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic signed [AUDIO_W-1:0] got);
         logic signed [AUDIO_W-1:0] want;
         if (expected_audio.size() == 0) begin
            $error("audio_sample: expected no frame, actual %0d", got);
            errors++;
         end else begin
            want = expected_audio.pop_front();
            if (got !== want) begin
               $error("audio_sample: expected %0d, actual %0d", want, got);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_audio.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [CMD_W-1:0]           req_command;
   logic [FIELD_ADDR_W-1:0]    req_address;
   logic signed [SAMPLE_W-1:0] req_sample_byte;
   logic [CHANNEL_W-1:0]       req_channel;
   logic                       req_voice_enable;
   logic [FIELD_ADDR_W-1:0]    req_voice_start;
   logic [FIELD_ADDR_W-1:0]    req_voice_length;
   logic [FIELD_ADDR_W-1:0]    req_loop_start;
   logic [FIELD_ADDR_W-1:0]    req_loop_length;
   logic [STEP_W-1:0]          req_step;
   logic [GAIN_W-1:0]          req_volume;
   logic                       req_restart_position;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [AUDIO_W-1:0]  rsp_audio_sample;
   logic                       csr_write;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   frame_scoreboard sb;
   int unsigned     accepted;
   bit              quiet;
   bit              hold_request;

   looping_sample_voice_mixer_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_address          (req_address),
      .req_sample_byte      (req_sample_byte),
      .req_channel          (req_channel),
      .req_voice_enable     (req_voice_enable),
      .req_voice_start      (req_voice_start),
      .req_voice_length     (req_voice_length),
      .req_loop_start       (req_loop_start),
      .req_loop_length      (req_loop_length),
      .req_step             (req_step),
      .req_volume           (req_volume),
      .req_restart_position (req_restart_position),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_audio_sample     (rsp_audio_sample),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // every field random; callers override what the command uses
   function automatic mixer_command_t random_fields();
      mixer_command_t c;
      c.command          = $urandom_range(0, 3);
      c.address          = $urandom_range(0, ADDR_MAX);
      c.sample_byte      = $urandom_range(0, 255);
      c.channel          = $urandom_range(0, VOICES - 1);
      c.voice_enable     = $urandom_range(0, 1);
      c.voice_start      = $urandom_range(0, ADDR_MAX);
      c.voice_length     = $urandom_range(0, ADDR_MAX);
      c.loop_start       = $urandom_range(0, ADDR_MAX);
      c.loop_length      = $urandom_range(0, ADDR_MAX);
      c.step             = $urandom_range(0, STEP_MAX);
      c.volume           = $urandom_range(0, 255);
      c.restart_position = $urandom_range(0, 1);
      return c;
   endfunction

   // voice setup: mostly short samples and slow steps, now and then the extremes
   function automatic mixer_command_t random_voice(int unsigned lim);
      mixer_command_t c;
      int unsigned    r;
      c = random_fields();
      c.command = CMD_SET_VOICE;
      if ($urandom_range(0, 3) != 0) c.channel = $urandom_range(0, lim - 1);
      c.voice_enable = ($urandom_range(0, 7) != 0);
      r = $urandom_range(0, 9);
      if (r == 0) c.voice_length = 0;
      else if (r <= 7) c.voice_length = $urandom_range(1, 256);
      else if (r == 8) c.voice_length = $urandom_range(0, ADDR_MAX);
      else c.voice_length = ADDR_MAX;
      if ($urandom_range(0, 7) != 0) c.loop_start = $urandom_range(0, c.voice_length);
      r = $urandom_range(0, 9);
      if (r <= 2) c.loop_length = 0;
      else if (r <= 8) c.loop_length = $urandom_range(1, c.voice_length + 1);
      r = $urandom_range(0, 19);
      if (r == 0) c.step = STEP_MAX;
      else if (r <= 2) c.step = $urandom_range(0, STEP_MAX);
      else c.step = $urandom_range(0, 4 * ONE_STEP);
      r = $urandom_range(0, 7);
      if (r == 0) c.volume = 0;
      else if (r == 1) c.volume = 255;
      return c;
   endfunction

   // one command transfer; an idle burst may come first
   task automatic send(input mixer_command_t c);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_command          = c.command;
      req_address          = c.address;
      req_sample_byte      = c.sample_byte;
      req_channel          = c.channel;
      req_voice_enable     = c.voice_enable;
      req_voice_start      = c.voice_start;
      req_voice_length     = c.voice_length;
      req_loop_start       = c.loop_start;
      req_loop_length      = c.loop_length;
      req_step             = c.step;
      req_volume           = c.volume;
      req_restart_position = c.restart_position;
      req_valid            = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(c);
      accepted++;
      if (accepted >= QUIET_FROM) quiet = 1'b1;
   endtask

   task automatic write_byte(int unsigned addr, logic [SAMPLE_W-1:0] value);
      mixer_command_t c;
      c = random_fields();
      c.command     = CMD_WRITE_SAMPLE;
      c.address     = addr;
      c.sample_byte = value;
      send(c);
   endtask

   task automatic set_voice(int unsigned ch, bit en, int unsigned start, int unsigned len,
                            int unsigned lbeg, int unsigned llen, int unsigned step,
                            int unsigned vol, bit restart);
      mixer_command_t c;
      c = random_fields();
      c.command          = CMD_SET_VOICE;
      c.channel          = ch;
      c.voice_enable     = en;
      c.voice_start      = start;
      c.voice_length     = len;
      c.loop_start       = lbeg;
      c.loop_length      = llen;
      c.step             = step;
      c.volume           = vol;
      c.restart_position = restart;
      send(c);
   endtask

   // render, first writing any byte the frame would fetch that holds no data yet
   task automatic render_frame();
      int unsigned    upcoming [$];
      mixer_command_t c;
      if (sb.playing) begin
         void'(sb.mix_voices(1'b0));
         upcoming = sb.fetch_addr;
         foreach (upcoming[i]) begin
            if (!sb.written[upcoming[i]]) write_byte(upcoming[i], $urandom_range(0, 255));
         end
      end
      c = random_fields();
      c.command = CMD_RENDER;
      send(c);
   endtask

   // drop valid, wait for every frame, then let the block go quiet
   task automatic settle(int unsigned cycles);
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // result side stalls: random bursts, and one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // result transfers
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(rsp_audio_sample);
   end

   // watchdog on cycles with no transfer of any kind
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0) || csr_write === 1'b1)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // stimulus
   initial begin
      mixer_command_t   c;
      int unsigned      v;
      int unsigned      phase;
      int unsigned      burst;
      int unsigned      k;
      int unsigned      sel;
      int unsigned      lim;
      int unsigned      cc;
      logic [CSR_DATA_W-1:0] data;
      sb = new();
      accepted     = 0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      req_valid    = 1'b0;
      c = random_fields();
      req_command          = c.command;
      req_address          = c.address;
      req_sample_byte      = c.sample_byte;
      req_channel          = c.channel;
      req_voice_enable     = c.voice_enable;
      req_voice_start      = c.voice_start;
      req_voice_length     = c.voice_length;
      req_loop_start       = c.loop_start;
      req_loop_length      = c.loop_length;
      req_step             = c.step;
      req_volume           = c.volume;
      req_restart_position = c.restart_position;
      csr_write = 1'b0;
      csr_index = CSR_CHANNEL_COUNT;
      csr_wdata = '0;
      reset     = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // playing is off after reset: a render gives silence; an unused code does nothing
      render_frame();
      c = random_fields();
      c.command = CMD_UNUSED;
      send(c);

      // four voices on the most negative byte at full volume saturate low
      write_byte(0, 8'h80);
      write_byte(1, 8'h7f);
      write_byte(ADDR_MAX, 8'h7f);
      for (v = 0; v < 4; v++) set_voice(v, 1'b1, 0, 1, 0, 0, 0, 255, 1'b1);
      settle(PHASE_GAP);
      write_reg(CSR_PLAYING_ENABLE, 6'd1);
      render_frame();
      // same on the most positive byte saturates high
      for (v = 0; v < 4; v++) set_voice(v, 1'b1, 1, 1, 0, 0, 0, 255, 1'b0);
      render_frame();

      // fetch wraps past the top of memory, then the loop jumps back
      settle(PHASE_GAP);
      write_reg(CSR_CHANNEL_COUNT, 6'd1);
      set_voice(0, 1'b1, ADDR_MAX, 2, 0, 2, ONE_STEP, 1, 1'b1);
      repeat (3) render_frame();

      // count beyond the voice limit reaches the last voice; count zero mixes none
      settle(PHASE_GAP);
      write_reg(CSR_CHANNEL_COUNT, 6'd63);
      set_voice(VOICES - 1, 1'b1, $urandom_range(0, ADDR_MAX), ADDR_MAX, 0, 0, STEP_MAX,
                255, 1'b1);
      render_frame();
      settle(PHASE_GAP);
      write_reg(CSR_CHANNEL_COUNT, 6'd0);
      render_frame();

      // one voice runs at the largest step through the longest sample until its
      // position passes the sample end; the result side holds off early on
      settle(PHASE_GAP);
      write_reg(CSR_CHANNEL_COUNT, 6'd1);
      hold_request = 1'b1;
      set_voice(0, 1'b1, $urandom_range(0, ADDR_MAX), ADDR_MAX, 0, 0, STEP_MAX,
                $urandom_range(0, 255), 1'b1);
      repeat (OVERFLOW_RUNS) render_frame();

      // random phases, each with its own register settings
      phase = 0;
      while (accepted < ITEM_TARGET) begin
         settle(PHASE_GAP);
         if ($urandom_range(0, 3) == 0) cc = $urandom_range(0, 63);
         else cc = COUNT_PICKS[$urandom_range(0, 10)];
         write_reg(CSR_CHANNEL_COUNT, cc);
         data = $urandom_range(0, 63);
         data[0] = ($urandom_range(0, 6) != 0);
         write_reg(CSR_PLAYING_ENABLE, data);
         if (phase % 5 == 2) hold_request = 1'b1;
         lim = (cc == 0 || cc > VOICES) ? VOICES : cc;
         burst = $urandom_range(40, 120);
         k = 0;
         while (k < burst && accepted < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
               send(random_voice(lim));
            end else if (sel < 32) begin
               write_byte($urandom_range(0, ADDR_MAX), $urandom_range(0, 255));
            end else if (sel < 35) begin
               c = random_fields();
               c.command = CMD_UNUSED;
               send(c);
            end else begin
               render_frame();
            end
            k++;
         end
         phase++;
      end

      // drain and look for stray frames
      settle(FRAME_CYCLES);
      if (sb.pending() != 0) begin
         $error("audio_sample: %0d expected frames never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
